>>> hdl/bqf_pkg.sv
// bqf_pkg: shared types and constants of the biquad lowpass/highpass filter
// used by the register block, controller, datapath and top level
`default_nettype none
package bqf_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 20;
  localparam int COEF_BITS          = 24;
  localparam int STATE_BITS         = 48;
  localparam int ADDR_W             = 5;
  localparam int DATA_W             = 32;
  localparam int REG_IDX_W          = ADDR_W - 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE,
    REG_LP_OUTER,
    REG_LP_MIDDLE,
    REG_HP_OUTER,
    REG_HP_MIDDLE,
    REG_FB_FIRST,
    REG_FB_SECOND
  } reg_idx_e;

  typedef enum logic {
    MODE_LOWPASS,
    MODE_HIGHPASS
  } mode_e;

  typedef struct packed {
    mode_e                        mode;
    logic signed [COEF_BITS-1:0]  lp_outer;
    logic signed [COEF_BITS-1:0]  lp_middle;
    logic signed [COEF_BITS-1:0]  hp_outer;
    logic signed [COEF_BITS-1:0]  hp_middle;
    logic signed [COEF_BITS-1:0]  fb_first;
    logic signed [COEF_BITS-1:0]  fb_second;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_OUTER_X,
    MUL_MIDDLE_X,
    MUL_FB1_Y,
    MUL_FB2_Y
  } mul_op_e;

  typedef struct packed {
    logic    ld_x;
    mul_op_e mul_op;
    logic    round_en;
    logic    acc_en;
    logic    wr_s1;
    logic    wr_s2;
    logic    push;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_OUTER,
    ST_ROUND,
    ST_FB1,
    ST_UPD_S1,
    ST_UPD_S2,
    ST_WAIT_OUT
  } ctrl_state_e;

endpackage
`default_nettype wire

>>> hdl/bqf_regs.sv
// bqf_regs: apb-style configuration registers (mode and six coefficients)
// depends on bqf_pkg
`default_nettype none
module bqf_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bqf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bqf_pkg::DATA_W-1:0]  pwdata,
  output logic      [bqf_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output bqf_pkg::cfg_t                    cfg_o
);

  localparam int CW = bqf_pkg::COEF_BITS;

  bqf_pkg::cfg_t     cfg_q, cfg_d;
  bqf_pkg::reg_idx_e idx;
  logic              wr_en;
  logic [CW-1:0]     wcoef;

  assign idx    = bqf_pkg::reg_idx_e'(paddr[bqf_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign wcoef  = pwdata[CW-1:0];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        bqf_pkg::REG_MODE:      cfg_d.mode      = bqf_pkg::mode_e'(pwdata[0]);
        bqf_pkg::REG_LP_OUTER:  cfg_d.lp_outer  = wcoef;
        bqf_pkg::REG_LP_MIDDLE: cfg_d.lp_middle = wcoef;
        bqf_pkg::REG_HP_OUTER:  cfg_d.hp_outer  = wcoef;
        bqf_pkg::REG_HP_MIDDLE: cfg_d.hp_middle = wcoef;
        bqf_pkg::REG_FB_FIRST:  cfg_d.fb_first  = wcoef;
        bqf_pkg::REG_FB_SECOND: cfg_d.fb_second = wcoef;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bqf_pkg::REG_MODE:      prdata = bqf_pkg::DATA_W'(cfg_q.mode);
      bqf_pkg::REG_LP_OUTER:  prdata = bqf_pkg::DATA_W'($unsigned(cfg_q.lp_outer));
      bqf_pkg::REG_LP_MIDDLE: prdata = bqf_pkg::DATA_W'($unsigned(cfg_q.lp_middle));
      bqf_pkg::REG_HP_OUTER:  prdata = bqf_pkg::DATA_W'($unsigned(cfg_q.hp_outer));
      bqf_pkg::REG_HP_MIDDLE: prdata = bqf_pkg::DATA_W'($unsigned(cfg_q.hp_middle));
      bqf_pkg::REG_FB_FIRST:  prdata = bqf_pkg::DATA_W'($unsigned(cfg_q.fb_first));
      bqf_pkg::REG_FB_SECOND: prdata = bqf_pkg::DATA_W'($unsigned(cfg_q.fb_second));
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/bqf_ctrl.sv
// bqf_ctrl: sequencer for one sample through the shared multiplier
// depends on bqf_pkg; drives bqf_dp through cmd_t, reads status_t
`default_nettype none
module bqf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bqf_pkg::status_t st_i,
  output bqf_pkg::cmd_t         cmd_o
);

  bqf_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bqf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_op = bqf_pkg::MUL_NONE;
    case (state_q)
      bqf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_x = 1'b1;
          state_d    = bqf_pkg::ST_MUL_OUTER;
        end
      end
      bqf_pkg::ST_MUL_OUTER: begin
        cmd_o.mul_op = bqf_pkg::MUL_OUTER_X;
        state_d      = bqf_pkg::ST_ROUND;
      end
      bqf_pkg::ST_ROUND: begin
        // output sample formed while the middle tap product starts
        cmd_o.round_en = 1'b1;
        cmd_o.mul_op   = bqf_pkg::MUL_MIDDLE_X;
        state_d        = bqf_pkg::ST_FB1;
      end
      bqf_pkg::ST_FB1: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.mul_op = bqf_pkg::MUL_FB1_Y;
        state_d      = bqf_pkg::ST_UPD_S1;
      end
      bqf_pkg::ST_UPD_S1: begin
        cmd_o.wr_s1  = 1'b1;
        cmd_o.mul_op = bqf_pkg::MUL_FB2_Y;
        state_d      = bqf_pkg::ST_UPD_S2;
      end
      bqf_pkg::ST_UPD_S2: begin
        cmd_o.wr_s2 = 1'b1;
        if (st_i.slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = bqf_pkg::ST_IDLE;
        end else begin
          state_d    = bqf_pkg::ST_WAIT_OUT;
        end
      end
      bqf_pkg::ST_WAIT_OUT: begin
        if (st_i.slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = bqf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bqf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/bqf_dp.sv
// bqf_dp: biquad datapath - shared multiplier, accumulator, section state,
// output word register; depends on bqf_pkg
`default_nettype none
module bqf_dp #(
  parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bqf_pkg::cfg_t           cfg_i,
  input  wire bqf_pkg::cmd_t           cmd_i,
  output bqf_pkg::status_t             st_o,
  input  wire logic [SAMPLE_BITS-1:0]  sample_in_i,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic      [SAMPLE_BITS-1:0]  sample_out_o
);

  localparam int SW  = SAMPLE_BITS;
  localparam int CW  = bqf_pkg::COEF_BITS;
  localparam int STW = bqf_pkg::STATE_BITS;
  localparam int PW  = SW + CW;
  localparam int MW  = (PW > STW) ? PW : STW;
  localparam int AW  = MW + 2;
  localparam logic signed [AW-1:0] ROUND_HALF =
    {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

  function automatic logic signed [SW-1:0] sat_sample(logic signed [AW-1:0] v);
    logic [AW-SW:0] top;
    top = v[AW-1:SW-1];
    if ((&top) || !(|top)) begin
      return v[SW-1:0];
    end
    return {v[AW-1], {(SW-1){~v[AW-1]}}};
  endfunction

  function automatic logic signed [STW-1:0] sat_state(logic signed [AW-1:0] v);
    logic [AW-STW:0] top;
    top = v[AW-1:STW-1];
    if ((&top) || !(|top)) begin
      return v[STW-1:0];
    end
    return {v[AW-1], {(STW-1){~v[AW-1]}}};
  endfunction

  logic signed [SW-1:0]  x_q, y_q, out_q;
  logic signed [PW-1:0]  p_q, g0x_q, prod;
  logic signed [AW-1:0]  acc_q;
  logic signed [STW-1:0] lp_s1_q, lp_s2_q, hp_s1_q, hp_s2_q;
  logic                  out_valid_q;

  logic signed [STW-1:0] s1_sel, s2_sel, s_new;
  logic signed [CW-1:0]  g_outer, g_middle, coef_op;
  logic signed [SW-1:0]  smp_op, y_d;
  logic signed [AW-1:0]  rnd_sum, rnd_shift, s1_sum, s2_sum;
  logic                  hp;

  assign hp       = (cfg_i.mode == bqf_pkg::MODE_HIGHPASS);
  assign g_outer  = hp ? cfg_i.hp_outer  : cfg_i.lp_outer;
  assign g_middle = hp ? cfg_i.hp_middle : cfg_i.lp_middle;
  assign s1_sel   = hp ? hp_s1_q : lp_s1_q;
  assign s2_sel   = hp ? hp_s2_q : lp_s2_q;

  always_comb begin
    case (cmd_i.mul_op)
      bqf_pkg::MUL_OUTER_X:  begin coef_op = g_outer;         smp_op = x_q; end
      bqf_pkg::MUL_MIDDLE_X: begin coef_op = g_middle;        smp_op = x_q; end
      bqf_pkg::MUL_FB1_Y:    begin coef_op = cfg_i.fb_first;  smp_op = y_q; end
      bqf_pkg::MUL_FB2_Y:    begin coef_op = cfg_i.fb_second; smp_op = y_q; end
      default:               begin coef_op = g_outer;         smp_op = x_q; end
    endcase
  end

  assign prod = PW'(coef_op) * PW'(smp_op);

  // y = sat(floor((a0*x + s1 + half) / 2^F))
  assign rnd_sum   = AW'(p_q) + AW'(s1_sel) + ROUND_HALF;
  assign rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
  assign y_d       = sat_sample(rnd_shift);

  // acc holds a1*x + s2, p holds b1*y during the s1 update
  assign s1_sum = acc_q - AW'(p_q);
  assign s2_sum = AW'(g0x_q) - AW'(p_q);
  assign s_new  = cmd_i.wr_s1 ? sat_state(s1_sum) : sat_state(s2_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_x) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.mul_op != bqf_pkg::MUL_NONE) begin
      p_q <= prod;
    end
    if (cmd_i.round_en) begin
      y_q   <= y_d;
      g0x_q <= p_q;
    end
    if (cmd_i.acc_en) begin
      acc_q <= AW'(p_q) + AW'(s2_sel);
    end
    if (cmd_i.push) begin
      out_q <= y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_s1_q <= '0;
      lp_s2_q <= '0;
      hp_s1_q <= '0;
      hp_s2_q <= '0;
    end else begin
      if (cmd_i.wr_s1 && !hp) lp_s1_q <= s_new;
      if (cmd_i.wr_s1 &&  hp) hp_s1_q <= s_new;
      if (cmd_i.wr_s2 && !hp) lp_s2_q <= s_new;
      if (cmd_i.wr_s2 &&  hp) hp_s2_q <= s_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign st_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_out_o   = out_q;

endmodule
`default_nettype wire

>>> hdl/biquad_lowpass_highpass_filter.sv
// biquad_lowpass_highpass_filter: second-order iir filter, transposed direct
// form ii, lowpass or highpass section picked by the mode register.
// Input channel: in_valid_i/in_ready_o with sample_in_i, one signed word per
// sample. Output channel: out_valid_o/out_ready_i with sample_out_o, one
// saturated signed word per input word, in order.
// Configuration: apb-style port, register i at byte address 4*i (mode, lp
// outer, lp middle, hp outer, hp middle, fb first, fb second). Write only
// while the filter is idle; pready is always high.
// Timing: a word is taken in the idle state and its result is written to the
// output register at the push; no new word is taken until that result is in the
// output register, since the four products of a sample go through the one
// shared multiplier in sequence.
// Stall: the output register holds a finished word while the next word is
// computed; if it is still full when the next result is ready, the sequencer
// waits and in_ready_o stays low until the receiver takes a word.
// Reset: the configuration registers and the four section state words clear to
// zero, the output is empty, mode is lowpass.
// Depends on bqf_pkg, bqf_regs, bqf_ctrl, bqf_dp.
`default_nettype none
module biquad_lowpass_highpass_filter #(
  parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bqf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bqf_pkg::DATA_W-1:0]  pwdata,
  output logic      [bqf_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]      sample_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [SAMPLE_BITS-1:0]      sample_out_o
);

  bqf_pkg::cfg_t    cfg;
  bqf_pkg::cmd_t    cmd;
  bqf_pkg::status_t st;

  bqf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bqf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bqf_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .st_o         (st),
    .sample_in_i  (sample_in_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o)
  );

endmodule
`default_nettype wire

>>> bench/tb_biquad_lowpass_highpass_filter.sv
// tb_biquad_lowpass_highpass_filter: self-checking bench for the biquad lowpass/highpass filter
// drives samples and apb register writes, checks each output word against an in-bench model
// depends on bqf_pkg and biquad_lowpass_highpass_filter
`timescale 1ns / 1ps
module tb_biquad_lowpass_highpass_filter;

  localparam int SBITS = bqf_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC = bqf_pkg::COEF_FRAC_BITS_DEF;
  localparam int CBITS = bqf_pkg::COEF_BITS;
  localparam int STBITS = bqf_pkg::STATE_BITS;
  localparam int IDXW = bqf_pkg::REG_IDX_W;
  localparam int DW = bqf_pkg::DATA_W;
  localparam int Q_ONE = 1 << FRAC;
  localparam int Q_NINE_TENTHS = 943718;
  localparam logic [IDXW-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [SBITS-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SBITS-1:0] S_MIN = 24'sh800000;
  localparam logic [DW-1:0] C_ONE = 32'h0010_0000;
  localparam logic [DW-1:0] C_HALF = 32'h0008_0000;
  localparam logic [DW-1:0] C_MAX = 32'h007F_FFFF;
  localparam logic [DW-1:0] C_MIN = 32'h0080_0000;
  localparam int SETTLE_LIMIT = 5000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int BATCHES = 5;
  localparam int BATCH_WORDS = 57;
  localparam int PLAN_ROWS = 32;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [IDXW-1:0]          reg_idx;
    logic [DW-1:0]            wdata;
    logic signed [SBITS-1:0]  sample;
    logic                     has_typed;
    logic signed [SBITS-1:0]  typed_out;
  } plan_row_t;

  // typed results only where the filter is still all zero
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         S_MAX,       1'b1, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         S_MIN,       1'b1, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         24'sd0,      1'b1, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         -24'sd1,     1'b1, 24'sd0},
    '{ROW_WRITE,  REG_UNUSED,             32'h007F_FFFF, 24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         S_MAX,       1'b1, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_LP_OUTER,  C_ONE,         24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         24'sd1,      1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         -24'sd1,     1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         24'sd12345,  1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_LP_OUTER,  C_MAX,         24'sd0,      1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_LP_MIDDLE, C_MIN,         24'sd0,      1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_FB_FIRST,  32'hA500_0000 | C_MAX, 24'sd0, 1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_FB_SECOND, 32'hFF00_0000 | C_MIN, 24'sd0, 1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         S_MAX,       1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         S_MIN,       1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         S_MAX,       1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         S_MIN,       1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_MODE,
      {31'h7FFF_FFFF, bqf_pkg::MODE_HIGHPASS},           24'sd0,      1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_HP_OUTER,  C_HALF,        24'sd0,      1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_HP_MIDDLE, 32'hFFF0_0000, 24'sd0,      1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_FB_FIRST,  32'h0,         24'sd0,      1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_FB_SECOND, 32'h0,         24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         24'sd1,      1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         -24'sd1,     1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         24'sd3,      1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         S_MIN,       1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_MODE,
      {31'h7FFF_FFFF, bqf_pkg::MODE_LOWPASS},            24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         24'sd100,    1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         -24'sd100,   1'b0, 24'sd0},
    '{ROW_WRITE,  bqf_pkg::REG_MODE,
      {31'd0, bqf_pkg::MODE_HIGHPASS},                   24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, bqf_pkg::REG_MODE,      32'h0,         24'sd0,      1'b0, 24'sd0}
  };

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [bqf_pkg::ADDR_W-1:0] paddr = '0;
  logic [DW-1:0]             pwdata = '0;
  logic [DW-1:0]             prdata;
  logic                      pready;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [SBITS-1:0]   sample_in_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [SBITS-1:0]          sample_out_o;

  // bench copy of the register file and of the four section state words
  bqf_pkg::cfg_t             filter_cfg = '0;
  logic signed [STBITS-1:0]  lp_s1 = '0, lp_s2 = '0, hp_s1 = '0, hp_s2 = '0;

  logic [SBITS-1:0]        expected_samples [$];
  logic signed [SBITS-1:0] last_sample = '0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatch_count = 0;
  int samples_sent = 0;
  int samples_checked = 0;
  int settings_count = 0;
  bit hold_request = 1'b0;
  logic hold_rx = 1'b0;

  biquad_lowpass_highpass_filter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d words still outstanding", expected_samples.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch (%s): expected %0h got %0h", what, want, got);
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one transposed direct form ii step on the selected section
  function automatic logic [SBITS-1:0] filter_step(logic signed [SBITS-1:0] x);
    longint g_outer, g_mid, b1, b2, s1, s2, acc, y, n1, n2;
    b1 = signed'(filter_cfg.fb_first);
    b2 = signed'(filter_cfg.fb_second);
    if (filter_cfg.mode == bqf_pkg::MODE_LOWPASS) begin
      g_outer = signed'(filter_cfg.lp_outer);
      g_mid = signed'(filter_cfg.lp_middle);
      s1 = lp_s1;
      s2 = lp_s2;
    end else begin
      g_outer = signed'(filter_cfg.hp_outer);
      g_mid = signed'(filter_cfg.hp_middle);
      s1 = hp_s1;
      s2 = hp_s2;
    end
    acc = g_outer * x + s1;
    // round half up, then clamp to the sample range; the clamped word is fed back
    y = clip((acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC, SBITS);
    n1 = clip(g_mid * x - b1 * y + s2, STBITS);
    n2 = clip(g_outer * x - b2 * y, STBITS);
    if (filter_cfg.mode == bqf_pkg::MODE_LOWPASS) begin
      lp_s1 = n1[STBITS-1:0];
      lp_s2 = n2[STBITS-1:0];
    end else begin
      hp_s1 = n1[STBITS-1:0];
      hp_s2 = n2[STBITS-1:0];
    end
    return y[SBITS-1:0];
  endfunction

  function automatic void apply_cfg_write(logic [IDXW-1:0] idx, logic [DW-1:0] data);
    case (idx)
      bqf_pkg::REG_MODE:      filter_cfg.mode = bqf_pkg::mode_e'(data[0]);
      bqf_pkg::REG_LP_OUTER:  filter_cfg.lp_outer = data[CBITS-1:0];
      bqf_pkg::REG_LP_MIDDLE: filter_cfg.lp_middle = data[CBITS-1:0];
      bqf_pkg::REG_HP_OUTER:  filter_cfg.hp_outer = data[CBITS-1:0];
      bqf_pkg::REG_HP_MIDDLE: filter_cfg.hp_middle = data[CBITS-1:0];
      bqf_pkg::REG_FB_FIRST:  filter_cfg.fb_first = data[CBITS-1:0];
      bqf_pkg::REG_FB_SECOND: filter_cfg.fb_second = data[CBITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CBITS-1:0] reg_mirror(logic [IDXW-1:0] idx);
    case (idx)
      bqf_pkg::REG_MODE:      return {23'd0, filter_cfg.mode};
      bqf_pkg::REG_LP_OUTER:  return filter_cfg.lp_outer;
      bqf_pkg::REG_LP_MIDDLE: return filter_cfg.lp_middle;
      bqf_pkg::REG_HP_OUTER:  return filter_cfg.hp_outer;
      bqf_pkg::REG_HP_MIDDLE: return filter_cfg.hp_middle;
      bqf_pkg::REG_FB_FIRST:  return filter_cfg.fb_first;
      bqf_pkg::REG_FB_SECOND: return filter_cfg.fb_second;
      default:                return '0;
    endcase
  endfunction

  function automatic logic [CBITS-1:0] wild_coef();
    case ($urandom_range(3))
      0: return C_MAX[CBITS-1:0];
      1: return C_MIN[CBITS-1:0];
      2: return '0;
      default: return CBITS'($urandom);
    endcase
  endfunction

  function automatic logic [CBITS-1:0] coef_in_span(int span);
    return CBITS'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [SBITS-1:0] next_random_sample();
    case ($urandom_range(9))
      0: last_sample = $urandom_range(1) ? S_MAX : S_MIN;
      1, 2: last_sample = SBITS'(int'($urandom_range(0, 2048)) - 1024);
      3, 4: ; // hold the previous word, step response
      default: last_sample = SBITS'($urandom);
    endcase
    return last_sample;
  endfunction

  // setup cycle, then access cycle; the register takes the word at the end of the access cycle
  task automatic apb_write(logic [IDXW-1:0] idx, logic [DW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    apply_cfg_write(idx, data);
  endtask

  task automatic apb_check_read(logic [IDXW-1:0] idx);
    logic [CBITS-1:0] got;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = (idx == bqf_pkg::REG_MODE) ? {23'd0, prdata[0]} : prdata[CBITS-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== reg_mirror(idx))
      note_mismatch("register readback", 32'(reg_mirror(idx)), 32'(got));
  endtask

  task automatic push_sample(logic signed [SBITS-1:0] x, logic has_typed,
                             logic signed [SBITS-1:0] typed_out);
    logic [SBITS-1:0] predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = filter_step(x);
    expected_samples.push_back(has_typed ? typed_out : predicted);
    samples_sent++;
  endtask

  // drop valid and wait for the filter to go idle before touching registers
  task automatic settle_outputs(int max_cycles);
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0 && waited < max_cycles) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_settings();
    logic [CBITS-1:0] lp_o, lp_m, hp_o, hp_m, b1, b2;
    int b2_i;
    int lim;
    settle_outputs(SETTLE_LIMIT);
    if ($urandom_range(4) == 0) begin
      lp_o = wild_coef();
      lp_m = wild_coef();
      hp_o = wild_coef();
      hp_m = wild_coef();
      b1 = wild_coef();
      b2 = wild_coef();
    end else begin
      // keep the poles inside the stability triangle so the output stays off the rails
      lp_o = coef_in_span(Q_ONE);
      lp_m = coef_in_span(2 * Q_ONE);
      hp_o = coef_in_span(Q_ONE);
      hp_m = coef_in_span(2 * Q_ONE);
      b2_i = int'($urandom_range(0, 2 * Q_NINE_TENTHS)) - Q_NINE_TENTHS;
      lim = ((Q_ONE + b2_i) / 20) * 19;
      b1 = coef_in_span(lim);
      b2 = CBITS'(b2_i);
    end
    apb_write(bqf_pkg::REG_MODE,
              {8'($urandom), 23'($urandom), bqf_pkg::mode_e'($urandom_range(1))});
    apb_write(bqf_pkg::REG_LP_OUTER, {8'($urandom), lp_o});
    apb_write(bqf_pkg::REG_LP_MIDDLE, {8'($urandom), lp_m});
    apb_write(bqf_pkg::REG_HP_OUTER, {8'($urandom), hp_o});
    apb_write(bqf_pkg::REG_HP_MIDDLE, {8'($urandom), hp_m});
    apb_write(bqf_pkg::REG_FB_FIRST, {8'($urandom), b1});
    apb_write(bqf_pkg::REG_FB_SECOND, {8'($urandom), b2});
    for (int r = bqf_pkg::REG_MODE; r <= bqf_pkg::REG_FB_SECOND; r++)
      apb_check_read(IDXW'(r));
    settings_count++;
  endtask

  always @(posedge clk_i)
    out_ready_i <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);

  initial begin
    wait (hold_request);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin : check_output
    logic [SBITS-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_samples.size() == 0) begin
        note_mismatch("word with nothing expected", '0, 32'(sample_out_o));
      end else begin
        want = expected_samples.pop_front();
        if (sample_out_o !== want)
          note_mismatch("sample_out", 32'(want), 32'(sample_out_o));
      end
      samples_checked++;
    end
  end

  initial begin : stimulus
    wait (rst_ni);
    @(posedge clk_i);
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_WRITE) begin
        settle_outputs(SETTLE_LIMIT);
        apb_write(directed_plan[i].reg_idx, directed_plan[i].wdata);
      end else begin
        push_sample(directed_plan[i].sample, directed_plan[i].has_typed,
                    directed_plan[i].typed_out);
      end
    end
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 47 : 0;
      rx_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 23 : 0;
      for (int b = 0; b < BATCHES; b++) begin
        random_settings();
        // long output stall while words keep coming, so the input backs up
        if (phase == 2 && b == 0) hold_request = 1'b1;
        repeat (BATCH_WORDS) push_sample(next_random_sample(), 1'b0, '0);
      end
    end
    settle_outputs(SETTLE_LIMIT);
    if (expected_samples.size() != 0) begin
      mismatch_count += expected_samples.size();
      $display("%0d expected words never arrived", expected_samples.size());
    end
    $display("summary: %0d samples sent, %0d words checked, %0d random filter settings",
             samples_sent, samples_checked, settings_count);
    $display("summary: both sections, saturating extremes, three idle mixes, one long stall");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
